FILE: design/pf565_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pf565_pkg;

	// source format codes
	localparam logic [1:0] FMT_RGB332 = 2'd0;
	localparam logic [1:0] FMT_RGB565 = 2'd1;
	localparam logic [1:0] FMT_RGB888 = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_image;
	} pf565_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_out;
	} pf565_out_t;

	// one finished pixel on its way to the byte serialiser
	typedef struct packed {
		logic [15:0] word;
		logic        last;
	} pf565_pix_t;

	// serialiser status seen by the top level
	typedef struct packed {
		logic valid;
		logic hi;
	} pf565_back_st_t;

	// bytes held before the byte that completes a pixel
	function automatic logic [1:0] pf565_need(input logic [1:0] fmt);
		logic [1:0] n;
		unique case (fmt)
			FMT_RGB332: n = 2'd0;
			FMT_RGB565: n = 2'd1;
			default:    n = 2'd2;
		endcase
		return n;
	endfunction

	// widen to rgb888 with zero low bits, then cut to r5 g6 b5
	function automatic logic [15:0] pf565_pack(input logic [1:0] fmt,
		input logic [15:0] held, input logic [7:0] data);
		logic [15:0] w;
		unique case (fmt)
			FMT_RGB332: w = {data[7:5], 2'b00, data[4:2], 3'b000, data[1:0], 3'b000};
			FMT_RGB565: w = {held[7:0], data};
			default:    w = {held[15:11], held[7:2], data[7:3]};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: design/pixel_format_to_rgb565_stream_core.sv
`timescale 1ns / 1ps
`default_nettype none
// converts a byte stream of rgb332, big-endian rgb565 or rgb888 pixels into
// rgb565 display bytes, low byte first; source_format is set through cfg_we and
// cfg_wdata (code 3 acts as rgb888); the user must write it only while the
// block is idle, which the block itself does not enforce. a front stage takes
// one image byte per cycle while the queue is not full, holds the partial pixel
// and packs the finished word; a two-entry pixel queue feeds a back stage that
// sends two beats per pixel, one per cycle while pop is held. the output holds
// back rgb332 bytes; rgb565 and rgb888 bytes go at one per cycle sustained. each
// pixel is registered in the queue and then the back stage before its low byte
// is out. last_out marks the high byte of a pixel completed by a byte with
// end_of_image; an unfinished pixel at end of image is dropped and gives no beat
module pixel_format_to_rgb565_stream_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_wdata,
	input  wire logic                  push,
	input  wire pf565_pkg::pf565_in_t  in_data,
	output logic                       full,
	output logic                       empty,
	input  wire logic                  pop,
	output pf565_pkg::pf565_out_t      out_data
);

	// front to queue
	logic                  fifo_push;
	pf565_pkg::pf565_pix_t fifo_pix;
	logic                  fifo_full;
	// queue to back
	logic                  rd_en;
	logic                  rd_valid;
	pf565_pkg::pf565_pix_t rd_pix;
	logic [1:0]            level;
	pf565_pkg::pf565_back_st_t back_st;

	// byte gathering and colour packing
	pf565_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.in_data   (in_data),
		.full      (full),
		.fifo_full (fifo_full),
		.fifo_push (fifo_push),
		.fifo_pix  (fifo_pix)
	);

	// short queue so each side stalls on its own
	pf565_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (fifo_push),
		.wr_pix    (fifo_pix),
		.fifo_full (fifo_full),
		.rd_en     (rd_en),
		.rd_valid  (rd_valid),
		.rd_pix    (rd_pix),
		.level     (level)
	);

	// two beats per pixel, low byte then high byte
	pf565_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (rd_valid),
		.rd_pix   (rd_pix),
		.rd_en    (rd_en),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data),
		.st       (back_st)
	);

	// queue never holds more than its two entries
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		level != 2'd3)
		else $error("pixel queue overfilled");

	// input side stalls only when the queue is full
	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		full == (level == 2'd2))
		else $error("full out of step with queue level");

	// a popped low byte is followed at once by its high byte
	a_hi_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !back_st.hi) |=> (!empty && back_st.hi))
		else $error("high byte missing after low byte");

	// end mark only ever on a high byte
	a_last_hi: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.last_out) |-> back_st.hi)
		else $error("last_out on a low byte");

endmodule
`default_nettype wire

FILE: design/pf565_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pf565_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_wdata,
	input  wire logic                  push,
	input  wire pf565_pkg::pf565_in_t  in_data,
	output logic                       full,
	input  wire logic                  fifo_full,
	output logic                       fifo_push,
	output pf565_pkg::pf565_pix_t      fifo_pix
);

	logic [1:0]  fmt_q;
	logic [1:0]  phase_q;
	logic [15:0] held_q;
	logic [1:0]  need;
	logic        complete;
	logic        accept;

	always_comb begin
		need      = pf565_pkg::pf565_need(fmt_q);
		complete  = (phase_q >= need);
		full      = fifo_full;
		accept    = push && !fifo_full;
		fifo_push = accept && complete;
		fifo_pix.word = pf565_pkg::pf565_pack(fmt_q, held_q, in_data.data_byte);
		fifo_pix.last = in_data.end_of_image;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= pf565_pkg::FMT_RGB332;
			phase_q <= 2'd0;
			held_q  <= 16'd0;
		end else begin
			if (cfg_we) begin
				fmt_q <= cfg_wdata;
			end
			if (accept) begin
				// finished pixel or end of image: start afresh
				if (complete || in_data.end_of_image) begin
					phase_q <= 2'd0;
					held_q  <= 16'd0;
				end else begin
					phase_q <= phase_q + 2'd1;
					held_q  <= {held_q[7:0], in_data.data_byte};
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/pf565_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module pf565_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire pf565_pkg::pf565_pix_t wr_pix,
	output logic                       fifo_full,
	input  wire logic                  rd_en,
	output logic                       rd_valid,
	output pf565_pkg::pf565_pix_t      rd_pix,
	output logic [1:0]                 level
);

	pf565_pkg::pf565_pix_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;
	logic       do_wr;
	logic       do_rd;

	always_comb begin
		fifo_full = (level_q == 2'd2);
		rd_valid  = (level_q != 2'd0);
		rd_pix    = mem_q[rd_ptr_q];
		level     = level_q;
		do_wr     = wr_en && !fifo_full;
		do_rd     = rd_en && rd_valid;
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/pf565_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pf565_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_valid,
	input  wire pf565_pkg::pf565_pix_t rd_pix,
	output logic                       rd_en,
	output logic                       empty,
	input  wire logic                  pop,
	output pf565_pkg::pf565_out_t      out_data,
	output pf565_pkg::pf565_back_st_t  st
);

	pf565_pkg::pf565_pix_t pix_q;
	logic valid_q;
	logic hi_q;
	logic take;

	always_comb begin
		take     = pop && valid_q;
		// load a new pixel when idle or as the high byte leaves
		rd_en    = rd_valid && (!valid_q || (take && hi_q));
		empty    = !valid_q;
		out_data.out_byte = hi_q ? pix_q.word[15:8] : pix_q.word[7:0];
		out_data.last_out = hi_q && pix_q.last;
		st.valid = valid_q;
		st.hi    = hi_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pix_q <= rd_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hi_q    <= 1'b0;
		end else begin
			if (rd_en) begin
				valid_q <= 1'b1;
				hi_q    <= 1'b0;
			end else if (take) begin
				if (hi_q) begin
					valid_q <= 1'b0;
					hi_q    <= 1'b0;
				end else begin
					hi_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: verif/pf565_stream_checker.sv
`timescale 1ns / 1ps
module pf565_stream_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_wdata,
	input  logic                  push,
	input  logic                  full,
	input  pf565_pkg::pf565_in_t  in_data,
	input  logic                  empty,
	input  logic                  pop,
	input  pf565_pkg::pf565_out_t out_data,
	output int                    mismatches,
	output int                    beats_owed
);
	import pf565_pkg::*;

	logic [1:0]  fmt_now;
	logic [1:0]  held_count;
	logic [15:0] held_pair;
	pf565_out_t  display_beats[$];
	int          errs;

	assign mismatches = errs;

	// one image byte in, zero or two display beats queued
	function automatic void convert_byte(input pf565_in_t b);
		logic [1:0]  need;
		logic [7:0]  d;
		logic [7:0]  r8, g8, b8;
		logic [15:0] pix, rgb;
		d = b.data_byte;
		case (fmt_now)
			FMT_RGB332: need = 2'd0;
			FMT_RGB565: need = 2'd1;
			default:    need = 2'd2;
		endcase
		if (held_count < need) begin
			if (b.end_of_image) begin
				held_count = '0;
				held_pair  = '0;
			end else begin
				held_pair  = {held_pair[7:0], d};
				held_count = held_count + 2'd1;
			end
			return;
		end
		case (need)
			2'd0: begin
				r8 = {d[7:5], 5'b0};
				g8 = {d[4:2], 5'b0};
				b8 = {d[1:0], 6'b0};
			end
			2'd1: begin
				pix = {held_pair[7:0], d};
				r8  = {pix[15:11], 3'b0};
				g8  = {pix[10:5], 2'b0};
				b8  = {pix[4:0], 3'b0};
			end
			default: begin
				r8 = held_pair[15:8];
				g8 = held_pair[7:0];
				b8 = d;
			end
		endcase
		rgb = {r8[7:3], g8[7:2], b8[7:3]};
		held_count = '0;
		held_pair  = '0;
		display_beats.push_back('{rgb[7:0], 1'b0});
		display_beats.push_back('{rgb[15:8], b.end_of_image});
	endfunction

	function automatic void check_beat(input pf565_out_t got);
		pf565_out_t want;
		if (display_beats.size() == 0) begin
			errs++;
			$display("%0t: unexpected beat, expected none, got byte %h last %b",
				$time, got.out_byte, got.last_out);
			return;
		end
		want = display_beats.pop_front();
		if (got.out_byte !== want.out_byte) begin
			errs++;
			$display("%0t: out_byte mismatch, expected %h, got %h",
				$time, want.out_byte, got.out_byte);
		end
		if (got.last_out !== want.last_out) begin
			errs++;
			$display("%0t: last_out mismatch, expected %b, got %b",
				$time, want.last_out, got.last_out);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_now    = FMT_RGB332;
			held_count = '0;
			held_pair  = '0;
			display_beats.delete();
			errs       = 0;
			beats_owed <= 0;
		end else begin
			if (pop && !empty)
				check_beat(out_data);
			// a byte taken on the same edge as a write still sees the old format
			if (push && !full)
				convert_byte(in_data);
			if (cfg_we)
				fmt_now = cfg_wdata;
			beats_owed <= display_beats.size();
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import pf565_pkg::*;

	// the spare format code, which the block treats as rgb888
	localparam logic [1:0] FMT_SPARE = 2'd3;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [1:0] cfg_wdata = '0;
	logic       push      = 1'b0;
	logic       pop       = 1'b0;
	pf565_in_t  in_data   = '0;
	logic       full;
	logic       empty;
	pf565_out_t out_data;

	int mismatches;
	int beats_owed;
	int sent   = 0;
	int popped = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pixel_format_to_rgb565_stream_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.in_data   (in_data),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.out_data  (out_data)
	);

	pf565_stream_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.full       (full),
		.in_data    (in_data),
		.empty      (empty),
		.pop        (pop),
		.out_data   (out_data),
		.mismatches (mismatches),
		.beats_owed (beats_owed)
	);

	// offer one image byte after a random gap; push is left high on return so
	// that back-to-back bytes never drop it between beats
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		int gap;
		// every fourth stretch of 32 bytes goes with no gaps at all
		gap = ((sent / 32) % 4 == 1) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		in_data <= '{b, eoi};
		do @(posedge clk); while (full);
		sent++;
	endtask

	// hold the input back until every predicted beat has left, then give the
	// block time to finish any byte that only updated its held pixel
	task automatic settle_output();
		push <= 1'b0;
		do @(posedge clk); while (beats_owed != 0);
		repeat (8) @(posedge clk);
	endtask

	// the format register is only touched once the block has gone quiet
	task automatic set_format(input logic [1:0] f);
		settle_output();
		cfg_we    <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one image of whole pixels with random content; now and then the last
	// pixel is cut short, or end of image is scattered at random as noise
	task automatic send_image(input logic [1:0] f);
		int         bpp;
		int         n;
		int         style;
		logic [7:0] b;
		logic       eoi;
		bpp   = (f == FMT_RGB332) ? 1 : (f == FMT_RGB565) ? 2 : 3;
		n     = bpp * $urandom_range(1, 12);
		style = $urandom_range(0, 9);
		if (style == 0 && bpp > 1)
			n = n - $urandom_range(1, bpp - 1);
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom);
			if ($urandom_range(0, 7) == 0)
				b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			eoi = (i == n - 1);
			if (style == 1 && $urandom_range(0, 7) == 0)
				eoi = 1'b1;
			send_byte(b, eoi);
		end
	endtask

	// result side: a random stall before each beat, with stall-free stretches
	initial begin : beat_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = ((popped / 40) % 3 == 0) ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			popped++;
		end
	end

	initial begin : stimulus
		int         target;
		int         phase_end;
		int         phase_no;
		logic [1:0] f;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rgb332 straight after reset: colour extremes and a mixed byte
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b1);

		// rgb565: white, black closing an image, then a lone byte at end of
		// image which must vanish without a beat
		set_format(FMT_RGB565);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h12, 1'b1);

		// rgb888: extremes per channel, low bits that truncation throws away,
		// and an image cut off after two bytes of its last pixel
		set_format(FMT_RGB888);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);

		// the spare code behaves as rgb888
		set_format(FMT_SPARE);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b1);

		// format changed with part of a pixel held: two rgb888 bytes finished
		// as rgb565, then one held byte overridden by rgb332
		set_format(FMT_RGB888);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h3C, 1'b0);
		set_format(FMT_RGB565);
		send_byte(8'h99, 1'b1);
		set_format(FMT_RGB888);
		send_byte(8'hAB, 1'b0);
		set_format(FMT_RGB332);
		send_byte(8'h5A, 1'b0);

		// random part: phases of whole images, each under its own format
		target   = sent + 1050;
		phase_no = 0;
		while (sent < target) begin
			case (phase_no % 5)
				0:       f = FMT_RGB332;
				1:       f = FMT_RGB565;
				2:       f = FMT_RGB888;
				3:       f = FMT_SPARE;
				default: f = 2'($urandom_range(0, 3));
			endcase
			set_format(f);
			phase_end = sent + $urandom_range(40, 120);
			if (phase_end > target)
				phase_end = target;
			send_image(f);
			// starve the input until the output has fully caught up
			settle_output();
			while (sent < phase_end)
				send_image(f);
			phase_no++;
		end

		settle_output();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
